FILE: hw/rtl/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared widths, codes, payload types and control links of the bitmap page
// frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

   localparam int OP_W     = 2;
   localparam int FRAME_FW = 12;
   localparam int ADDR_W   = 24;
   localparam int STATUS_W = 2;
   localparam int FREE_W   = 25;
   localparam int TOTAL_W  = 13;

   localparam int TOTAL_RESET = 4096;

   localparam int MAX_FRAMES_DEF      = 4096;
   localparam int PAGE_SHIFT_DEF      = 12;
   localparam int FRAMES_PER_WORD_DEF = 8;
   localparam int RAM_WIDTH_DEF       = 8;
   localparam int RAM_DEPTH_DEF       = 512;

   localparam logic [OP_W-1:0] OP_ALLOC     = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE_ADDR = 2'd1;
   localparam logic [OP_W-1:0] OP_MARK_USED = 2'd2;
   localparam logic [OP_W-1:0] OP_MARK_FREE = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OOM   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic [FRAME_FW-1:0] frame;
      logic [ADDR_W-1:0]   address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   block_address;
      logic [STATUS_W-1:0] status;
      logic                changed;
      logic [FREE_W-1:0]   free_bytes;
   } rsp_type;

   typedef struct packed {
      logic clear_wr;
      logic load_req;
      logic res_oom;
      logic res_range;
      logic map_rd;
      logic modify;
      logic scan_start;
      logic scan_rd;
      logic scan_next;
      logic alloc_hit;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic op_alloc;
      logic alloc_oom;
      logic in_range;
      logic word_free;
      logic scan_last;
      logic rsp_free;
   } sts_type;

endpackage

FILE: hw/rtl/bpfa_ram.sv
// ----------------------------------------------------------------------------
// bpfa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bpfa_ram #(
   parameter int WIDTH = bpfa_pkg::RAM_WIDTH_DEF,
   parameter int DEPTH = bpfa_pkg::RAM_DEPTH_DEF,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/bpfa_ctrl.sv
// ----------------------------------------------------------------------------
// bpfa_ctrl
// Sequencer: map clearing pass, request decode, word scan for allocation,
// read-modify-write for mark and free, result hand-off.
// ----------------------------------------------------------------------------
module bpfa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              req_valid,
   output logic              req_stall,
   input  bpfa_pkg::sts_type sts,
   output bpfa_pkg::cmd_type cmd
);
   import bpfa_pkg::*;

   localparam int STATE_W = 4;
   localparam logic [STATE_W-1:0] S_CLEAR    = 4'd0;
   localparam logic [STATE_W-1:0] S_IDLE     = 4'd1;
   localparam logic [STATE_W-1:0] S_START    = 4'd2;
   localparam logic [STATE_W-1:0] S_RD       = 4'd3;
   localparam logic [STATE_W-1:0] S_MOD      = 4'd4;
   localparam logic [STATE_W-1:0] S_SCAN_RD  = 4'd5;
   localparam logic [STATE_W-1:0] S_SCAN_CHK = 4'd6;
   localparam logic [STATE_W-1:0] S_DONE     = 4'd7;

   logic [STATE_W-1:0] state_ff;
   logic [STATE_W-1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != S_IDLE) || csr_wr_en;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid && !csr_wr_en) begin
               cmd.load_req = 1'b1;
               state_in     = S_START;
            end
         end
         S_START: begin
            if (sts.op_alloc) begin
               if (sts.alloc_oom) begin
                  cmd.res_oom = 1'b1;
                  state_in    = S_DONE;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN_RD;
               end
            end else if (!sts.in_range) begin
               cmd.res_range = 1'b1;
               state_in      = S_DONE;
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.map_rd = 1'b1;
            state_in   = S_MOD;
         end
         S_MOD: begin
            cmd.modify = 1'b1;
            state_in   = S_DONE;
         end
         S_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (sts.word_free) begin
               cmd.alloc_hit = 1'b1;
               state_in      = S_DONE;
            end else if (sts.scan_last) begin
               cmd.res_oom = 1'b1;
               state_in    = S_DONE;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
      if (csr_wr_en) begin
         state_in = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> state_ff == S_CLEAR)
      else $error("total write did not restart the clearing pass");
   a_req_start: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |=> state_ff == S_START)
      else $error("accepted request did not enter decode");
`endif

endmodule

FILE: hw/rtl/bpfa_dp.sv
// ----------------------------------------------------------------------------
// bpfa_dp
// Datapath: used bitmap RAM, frame total and used count, frame to word split,
// first-free word scan, result and output registers.
// ----------------------------------------------------------------------------
module bpfa_dp #(
   parameter int MAX_FRAMES      = bpfa_pkg::MAX_FRAMES_DEF,
   parameter int PAGE_SHIFT      = bpfa_pkg::PAGE_SHIFT_DEF,
   parameter int FRAMES_PER_WORD = bpfa_pkg::FRAMES_PER_WORD_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [bpfa_pkg::TOTAL_W-1:0] csr_wr_data,
   input  bpfa_pkg::req_type            req_data,
   input  logic                         rsp_stall,
   output logic                         rsp_valid,
   output bpfa_pkg::rsp_type            rsp_data,
   input  bpfa_pkg::cmd_type            cmd,
   output bpfa_pkg::sts_type            sts
);
   import bpfa_pkg::*;

   localparam int MAP_WORDS = (MAX_FRAMES + FRAMES_PER_WORD - 1) / FRAMES_PER_WORD;
   localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W     = $clog2(FRAMES_PER_WORD);
   localparam int FRAME_W   = (ADDR_W - PAGE_SHIFT > FRAME_FW) ? ADDR_W - PAGE_SHIFT : FRAME_FW;
   localparam int CMP_W     = (FRAME_W > TOTAL_W) ? FRAME_W : TOTAL_W;
   // exact divide by words for values below 2**TOTAL_W
   localparam int DIV_SHIFT = TOTAL_W + BIT_W;
   localparam int RECIP     = ((1 << DIV_SHIFT) + FRAMES_PER_WORD - 1) / FRAMES_PER_WORD;
   localparam int RECIP_W   = TOTAL_W + 1;
   localparam int PROD_W    = TOTAL_W + RECIP_W;
   localparam int Q_W       = PROD_W - DIV_SHIFT;
   localparam int CNT_W     = ((WORD_AW > Q_W) ? WORD_AW : Q_W) + 1;
   localparam int MAX_CLIP  = (MAX_FRAMES < (1 << TOTAL_W)) ? MAX_FRAMES : (1 << TOTAL_W) - 1;
   localparam int RESET_EFF = (TOTAL_RESET < MAX_CLIP) ? TOTAL_RESET : MAX_CLIP;
   localparam int SH_W      = TOTAL_W + PAGE_SHIFT;

   function automatic logic [TOTAL_W-1:0] clip_total(input logic [TOTAL_W-1:0] t);
      clip_total = (t > TOTAL_W'(MAX_CLIP)) ? TOTAL_W'(MAX_CLIP) : t;
   endfunction

   logic [TOTAL_W-1:0]         total_ff;
   logic [TOTAL_W-1:0]         eff_total;
   logic [TOTAL_W-1:0]         used_count_ff;
   logic [TOTAL_W-1:0]         used_count_in;
   req_type                    req_ff;
   logic [FRAME_W-1:0]         frame_sel;
   logic [TOTAL_W-1:0]         frame_lo;
   logic [PROD_W-1:0]          prod_ff;
   logic [PROD_W-1:0]          lim_prod_ff;
   logic [Q_W-1:0]             word_q;
   logic [Q_W-1:0]             word_lim_ff;
   logic [BIT_W-1:0]           bit_idx;
   logic [WORD_AW-1:0]         word_ff;
   logic [BIT_W-1:0]           bit_ff;
   logic [WORD_AW-1:0]         sweep_ff;
   logic [WORD_AW-1:0]         scan_ff;
   logic [ADDR_W-1:0]          res_addr_ff;
   logic [STATUS_W-1:0]        res_status_ff;
   logic                       res_changed_ff;
   rsp_type                    rsp_ff;
   logic                       rsp_valid_ff;

   logic                       wr_en;
   logic [WORD_AW-1:0]         wr_addr;
   logic [FRAMES_PER_WORD-1:0] wr_data;
   logic                       rd_en;
   logic [WORD_AW-1:0]         rd_addr;
   logic [FRAMES_PER_WORD-1:0] rd_data;

   logic [FRAMES_PER_WORD-1:0] inv_word;
   logic [FRAMES_PER_WORD-1:0] hit_mask;
   logic [BIT_W-1:0]           hit_idx;
   logic [TOTAL_W-1:0]         hit_frame;
   logic [SH_W-1:0]            hit_sh;
   logic [FRAMES_PER_WORD-1:0] bit_mask;
   logic                       bit_val;
   logic                       set_op;
   logic                       clr_op;
   logic                       mod_change;
   logic [FRAMES_PER_WORD-1:0] mod_word;
   logic [TOTAL_W-1:0]         free_cnt;
   logic [SH_W-1:0]            free_sh;

   assign eff_total = clip_total(total_ff);

   // frame to word and bit
   assign frame_sel = (req_ff.operation == OP_FREE_ADDR) ?
                      FRAME_W'(req_ff.address >> PAGE_SHIFT) : FRAME_W'(req_ff.frame);
   assign frame_lo  = TOTAL_W'(frame_sel);
   assign word_q    = Q_W'(prod_ff >> DIV_SHIFT);
   assign bit_idx   = BIT_W'(frame_lo - TOTAL_W'(int'(word_q) * FRAMES_PER_WORD));

   always_ff @(posedge clock) begin
      prod_ff     <= PROD_W'(frame_lo) * PROD_W'(RECIP);
      lim_prod_ff <= PROD_W'(eff_total) * PROD_W'(RECIP);
      word_lim_ff <= Q_W'(lim_prod_ff >> DIV_SHIFT);
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.map_rd) begin
         word_ff <= WORD_AW'(word_q);
         bit_ff  <= bit_idx;
      end
   end

   // lowest free frame of the scanned word
   assign inv_word = ~rd_data;
   assign hit_mask = inv_word & (~inv_word + FRAMES_PER_WORD'(1));

   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < FRAMES_PER_WORD; i++) begin
         if (hit_mask[i]) begin
            hit_idx = hit_idx | BIT_W'(i);
         end
      end
   end

   assign hit_frame = TOTAL_W'(int'(scan_ff) * FRAMES_PER_WORD + int'(hit_idx));
   assign hit_sh    = SH_W'(hit_frame) << PAGE_SHIFT;

   // mark and free
   assign bit_mask   = FRAMES_PER_WORD'(1) << bit_ff;
   assign bit_val    = rd_data[bit_ff];
   assign set_op     = req_ff.operation == OP_MARK_USED;
   assign clr_op     = (req_ff.operation == OP_FREE_ADDR) || (req_ff.operation == OP_MARK_FREE);
   assign mod_change = set_op ? !bit_val : (clr_op && bit_val);
   assign mod_word   = set_op ? (rd_data | bit_mask) : (rd_data & ~bit_mask);

   // map RAM ports
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = sweep_ff;
      wr_data = '1;
      if (cmd.clear_wr) begin
         wr_en = 1'b1;
      end else if (cmd.alloc_hit) begin
         wr_en   = 1'b1;
         wr_addr = scan_ff;
         wr_data = rd_data | hit_mask;
      end else if (cmd.modify) begin
         wr_en   = mod_change;
         wr_addr = word_ff;
         wr_data = mod_word;
      end
   end

   assign rd_en   = cmd.map_rd || cmd.scan_rd;
   assign rd_addr = cmd.scan_rd ? scan_ff : WORD_AW'(word_q);

   bpfa_ram #(
      .WIDTH (FRAMES_PER_WORD),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // total and used count
   always_comb begin
      used_count_in = used_count_ff;
      if (csr_wr_en) begin
         used_count_in = clip_total(csr_wr_data);
      end else if (cmd.alloc_hit) begin
         used_count_in = used_count_ff + 1'b1;
      end else if (cmd.modify && mod_change) begin
         if (set_op) begin
            if (used_count_ff < eff_total) begin
               used_count_in = used_count_ff + 1'b1;
            end
         end else if (used_count_ff != '0) begin
            used_count_in = used_count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= TOTAL_W'(TOTAL_RESET);
         used_count_ff <= TOTAL_W'(RESET_EFF);
         sweep_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            total_ff <= csr_wr_data;
         end
         used_count_ff <= used_count_in;
         if (csr_wr_en || (cmd.clear_wr && sts.sweep_last)) begin
            sweep_ff <= '0;
         end else if (cmd.clear_wr) begin
            sweep_ff <= sweep_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         scan_ff <= '0;
      end else if (cmd.scan_next) begin
         scan_ff <= scan_ff + 1'b1;
      end
   end

   // result
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         res_addr_ff    <= '0;
         res_status_ff  <= STATUS_OK;
         res_changed_ff <= 1'b0;
      end else if (cmd.res_oom) begin
         res_status_ff <= STATUS_OOM;
      end else if (cmd.res_range) begin
         res_status_ff <= STATUS_RANGE;
      end else if (cmd.modify) begin
         res_changed_ff <= mod_change;
      end else if (cmd.alloc_hit) begin
         res_addr_ff    <= ADDR_W'(hit_sh);
         res_changed_ff <= 1'b1;
      end
   end

   assign free_cnt = eff_total - used_count_ff;
   assign free_sh  = SH_W'(free_cnt) << PAGE_SHIFT;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_ff.block_address <= res_addr_ff;
         rsp_ff.status        <= res_status_ff;
         rsp_ff.changed       <= res_changed_ff;
         rsp_ff.free_bytes    <= FREE_W'(free_sh);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // status to the sequencer
   assign sts.sweep_last = sweep_ff == WORD_AW'(MAP_WORDS - 1);
   assign sts.op_alloc   = req_ff.operation == OP_ALLOC;
   assign sts.alloc_oom  = (used_count_ff >= eff_total) || (word_lim_ff == '0);
   assign sts.in_range   = CMP_W'(frame_sel) < CMP_W'(eff_total);
   assign sts.word_free  = |inv_word;
   assign sts.scan_last  = (CNT_W'(scan_ff) + CNT_W'(1)) >= CNT_W'(word_lim_ff);
   assign sts.rsp_free   = !rsp_valid_ff || !rsp_stall;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      used_count_ff <= eff_total)
      else $error("used count above frame total");
   a_alloc_count: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_hit && !csr_wr_en |=>
         used_count_ff == TOTAL_W'($past(used_count_ff) + 1'b1))
      else $error("allocation did not bump the used count");
`endif

endmodule

FILE: hw/rtl/bitmap_page_frame_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_top
// Mark and free requests: decode, map read, then modify, before the result
// is handed off; out-of-range requests and allocations refused at decode (map
// full or no whole word) go from decode straight to the result. Allocation with
// a scan reads one RAM word and checks it in the next cycle, word by word.
// The next request is taken in the cycle after the result is registered.
// Reset and every total write run a clearing pass over every bitmap word
// (512 at defaults) during which requests are stalled.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_top #(
   parameter int MAX_FRAMES      = bpfa_pkg::MAX_FRAMES_DEF,
   parameter int PAGE_SHIFT      = bpfa_pkg::PAGE_SHIFT_DEF,
   parameter int FRAMES_PER_WORD = bpfa_pkg::FRAMES_PER_WORD_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [bpfa_pkg::TOTAL_W-1:0] csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  bpfa_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output bpfa_pkg::rsp_type            rsp_data
);
   import bpfa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bpfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bpfa_dp #(
      .MAX_FRAMES      (MAX_FRAMES),
      .PAGE_SHIFT      (PAGE_SHIFT),
      .FRAMES_PER_WORD (FRAMES_PER_WORD)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

FILE: sim/bpfa_checker.sv
// ----------------------------------------------------------------------------
// bpfa_checker
// Watches the request, result and total-write ports of the page frame
// allocator. It keeps its own frame bitmap and used count, works out each
// result as a request is accepted, and compares results in order, field by
// field. The failure count and the number of results still owed go to the top.
// ----------------------------------------------------------------------------
module bpfa_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [bpfa_pkg::TOTAL_W-1:0] csr_wr_data,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  bpfa_pkg::req_type            req_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  bpfa_pkg::rsp_type            rsp_data,
   output int unsigned                  fail_count,
   output int unsigned                  pending,
   output int unsigned                  checked
);
   import bpfa_pkg::*;

   localparam int NUM_FRAMES = MAX_FRAMES_DEF;
   localparam int PSHIFT     = PAGE_SHIFT_DEF;
   localparam int WORD_BITS  = FRAMES_PER_WORD_DEF;

   bit                 frame_used [NUM_FRAMES];
   logic [TOTAL_W-1:0] total_setting;
   int unsigned        frames_in_use;
   rsp_type            pending_results[$];

   function automatic int unsigned capped_total();
      return (total_setting > NUM_FRAMES) ? NUM_FRAMES : int'(total_setting);
   endfunction

   function automatic void refill_map(logic [TOTAL_W-1:0] t);
      total_setting = t;
      foreach (frame_used[i]) frame_used[i] = 1'b1;
      frames_in_use = capped_total();
   endfunction

   function automatic rsp_type apply_request(req_type r);
      int unsigned tot;
      int unsigned f;
      int          found;
      rsp_type     o;
      tot   = capped_total();
      o     = '0;
      found = -1;
      if (r.operation == OP_ALLOC) begin
         // first fit over whole words only; tail frames are never handed out
         if (frames_in_use < tot)
            for (int i = 0; i < (tot / WORD_BITS) * WORD_BITS && found < 0; i++)
               if (!frame_used[i]) found = i;
         if (found < 0) begin
            o.status = STATUS_OOM;
         end else begin
            frame_used[found] = 1'b1;
            frames_in_use++;
            o.changed       = 1'b1;
            o.block_address = ADDR_W'(found << PSHIFT);
         end
      end else begin
         if (r.operation == OP_FREE_ADDR)
            f = r.address >> PSHIFT;
         else
            f = r.frame;
         if (f >= tot) begin
            o.status = STATUS_RANGE;
         end else if (r.operation == OP_MARK_USED) begin
            if (!frame_used[f]) begin
               frame_used[f] = 1'b1;
               if (frames_in_use < tot) frames_in_use++;
               o.changed = 1'b1;
            end
         end else if (frame_used[f]) begin
            frame_used[f] = 1'b0;
            if (frames_in_use > 0) frames_in_use--;
            o.changed = 1'b1;
         end
      end
      o.free_bytes = FREE_W'((tot - frames_in_use) << PSHIFT);
      return o;
   endfunction

   initial begin
      fail_count = 0;
      pending    = 0;
      checked    = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         refill_map(TOTAL_W'(TOTAL_RESET));
         pending_results.delete();
      end else begin
         if (csr_wr_en) refill_map(csr_wr_data);
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result: addr %h status %0d changed %0d free %h",
                           rsp_data.block_address, rsp_data.status,
                           rsp_data.changed, rsp_data.free_bytes);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               checked++;
               if (rsp_data.block_address !== want.block_address ||
                   rsp_data.status !== want.status ||
                   rsp_data.changed !== want.changed ||
                   rsp_data.free_bytes !== want.free_bytes) begin
                  if (fail_count < 10)
                     $display({"mismatch on result %0d: expected addr %h status %0d ",
                               "changed %0d free %h, got addr %h status %0d ",
                               "changed %0d free %h"},
                              checked, want.block_address, want.status,
                              want.changed, want.free_bytes,
                              rsp_data.block_address, rsp_data.status,
                              rsp_data.changed, rsp_data.free_bytes);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) pending_results.push_back(apply_request(req_data));
      end
      pending = pending_results.size();
   end

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the bitmap page frame allocator. A directed opening covers
// empty and full maps, tail frames, out-of-range frames, no-op marks and a
// saturating total; random phases then run many totals with random request
// mixes and random idling on both sides, one long result hold-off and a
// quiet closing phase. Results are checked by bpfa_checker.
// ----------------------------------------------------------------------------
module tb_top;
   import bpfa_pkg::*;

   localparam int CYCLE_LIMIT = 8_000_000;
   localparam int PHASES      = 13;
   localparam int PHASE_ITEMS = 130;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [TOTAL_W-1:0] csr_wr_data;
   logic               req_valid;
   logic               req_stall;
   req_type            req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   rsp_type            rsp_data;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned checked;
   int unsigned hold_cycles    = 0;
   int unsigned requests_sent  = 0;
   int unsigned settings_used  = 1;
   int unsigned cycles         = 0;
   bit          gaps_on        = 1'b0;

   bitmap_page_frame_allocator_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   bpfa_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .pending     (pending),
      .checked     (checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // result side: random stall bursts, plus a long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
            rsp_stall <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic req_type make_request(logic [OP_W-1:0] op,
                                            logic [FRAME_FW-1:0] fr,
                                            logic [ADDR_W-1:0] ad);
      req_type r;
      r.operation = op;
      r.frame     = fr;
      r.address   = ad;
      return r;
   endfunction

   function automatic req_type random_request(int unsigned tot);
      req_type     r;
      int unsigned pick;
      int unsigned f;
      r.frame   = FRAME_FW'($urandom);
      r.address = ADDR_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 30)      r.operation = OP_ALLOC;
      else if (pick < 45) r.operation = OP_FREE_ADDR;
      else if (pick < 75) r.operation = OP_MARK_FREE;
      else                r.operation = OP_MARK_USED;
      // mostly a low window so the map churns and scans stay short
      pick = $urandom_range(0, 99);
      if (tot == 0 || pick < 10) f = $urandom_range(0, 4095);
      else if (pick < 30)        f = $urandom_range(0, tot - 1);
      else                       f = $urandom_range(0, ((tot < 192) ? tot : 192) - 1);
      if (r.operation == OP_FREE_ADDR)
         r.address = {FRAME_FW'(f), 12'($urandom)};
      else if (r.operation != OP_ALLOC)
         r.frame = FRAME_FW'(f);
      return r;
   endfunction

   // entered and left at a falling edge; valid stays high for a following request
   task automatic send(input req_type r);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic write_total(input logic [TOTAL_W-1:0] t);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      csr_wr_data <= t;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   initial begin
      int unsigned totals [PHASES];
      int unsigned tot;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      totals = '{4096, 1, 8, 13, 100, 8191, 2048, 4095, 257, 0, 0, 0, 64};
      totals[10] = $urandom_range(0, 8191);
      totals[11] = $urandom_range(0, 8191);
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // full map after reset, then frames at both ends
      send(make_request(OP_ALLOC, '0, '0));
      send(make_request(OP_MARK_FREE, 12'd0, '0));
      send(make_request(OP_MARK_FREE, 12'd0, '0));
      send(make_request(OP_ALLOC, 12'hFFF, 24'hFFFFFF));
      send(make_request(OP_MARK_USED, 12'd0, '0));
      send(make_request(OP_FREE_ADDR, '0, 24'h000FFF));
      send(make_request(OP_MARK_FREE, 12'hFFF, '0));
      send(make_request(OP_ALLOC, '0, '0));
      send(make_request(OP_ALLOC, '0, '0));
      send(make_request(OP_FREE_ADDR, '0, 24'hFFFFFF));
      send(make_request(OP_MARK_USED, 12'hFFF, '0));

      // tail frames 8..12 and out-of-range frames
      write_total(13'd13);
      send(make_request(OP_MARK_FREE, 12'd12, '0));
      send(make_request(OP_ALLOC, '0, '0));
      send(make_request(OP_MARK_FREE, 12'd3, '0));
      send(make_request(OP_ALLOC, '0, '0));
      send(make_request(OP_MARK_USED, 12'd13, '0));
      send(make_request(OP_FREE_ADDR, '0, 24'h00D000));
      send(make_request(OP_MARK_FREE, 12'hFFF, '0));
      send(make_request(OP_FREE_ADDR, '0, 24'hFFFFFF));
      send(make_request(OP_FREE_ADDR, '0, 24'h00C123));

      write_total(13'd0);
      send(make_request(OP_ALLOC, '0, '0));
      send(make_request(OP_MARK_FREE, 12'd0, '0));

      // saturates to the full map size
      write_total(13'h1FFF);
      send(make_request(OP_MARK_FREE, 12'hFFF, '0));
      send(make_request(OP_ALLOC, '0, '0));

      for (int p = 0; p < PHASES; p++) begin
         write_total(TOTAL_W'(totals[p]));
         tot = (totals[p] > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : totals[p];
         gaps_on = (p != 3) && (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 3 && n == 40) hold_cycles = 300;
            send(random_request(tot));
         end
      end

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);

      $display("Covered %0d requests over %0d total settings (zero, tail, full, saturating).",
               requests_sent, settings_used);
      $display("Compared %0d results field by field; %0d failures.", checked, fail_count);
      if (fail_count == 0 && pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/bpfa_pkg.sv
hw/rtl/bpfa_ram.sv
hw/rtl/bpfa_ctrl.sv
hw/rtl/bpfa_dp.sv
hw/rtl/bitmap_page_frame_allocator_top.sv
sim/bpfa_checker.sv
sim/tb_top.sv
